// ----- rtl/zalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z80 ALU package
// Operation codes, word widths and flag bit positions shared by the ALU.
// ----------------------------------------------------------------------------
package zalu_pkg;

  localparam int unsigned UserWidth = 6;   // operation code
  localparam int unsigned InWidth   = 64;  // 63 bits of fields, padded to bytes
  localparam int unsigned OutWidth  = 40;  // 33 bits of fields, padded to bytes

  // Flag bit positions.
  localparam int unsigned FlS  = 7;
  localparam int unsigned FlZ  = 6;
  localparam int unsigned FlY  = 5;
  localparam int unsigned FlH  = 4;
  localparam int unsigned FlX  = 3;
  localparam int unsigned FlPv = 2;
  localparam int unsigned FlN  = 1;
  localparam int unsigned FlC  = 0;

  typedef enum logic [5:0] {
    OpAdd   = 6'd0,  OpAdc   = 6'd1,  OpSub   = 6'd2,  OpSbc   = 6'd3,
    OpAnd   = 6'd4,  OpXor   = 6'd5,  OpOr    = 6'd6,  OpCp    = 6'd7,
    OpIn    = 6'd8,  OpInc   = 6'd9,  OpDec   = 6'd10, OpRlca  = 6'd11,
    OpRrca  = 6'd12, OpRla   = 6'd13, OpRra   = 6'd14, OpDaa   = 6'd15,
    OpCpl   = 6'd16, OpScf   = 6'd17, OpCcf   = 6'd18, OpAdd16 = 6'd19,
    OpAdc16 = 6'd20, OpSbc16 = 6'd21, OpLdAir = 6'd22, OpLdi   = 6'd23,
    OpCpi   = 6'd24, OpIni   = 6'd25, OpOuti  = 6'd26, OpRrd   = 6'd27,
    OpRld   = 6'd28, OpRlc   = 6'd29, OpRrc   = 6'd30, OpRl    = 6'd31,
    OpRr    = 6'd32, OpSla   = 6'd33, OpSra   = 6'd34, OpSll   = 6'd35,
    OpSrl   = 6'd36, OpBit   = 6'd37, OpRes   = 6'd38, OpSet   = 6'd39
  } op_e;

  // Sign, zero, Y, X and parity flags of a byte.
  function automatic logic [7:0] szp(input logic [7:0] v);
    logic [7:0] f;
    f = {v[7], (v == 8'h00), v[5], 1'b0, v[3], ~^v, 2'b00};
    return f;
  endfunction

endpackage

// ----- rtl/z80_alu_with_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z80 ALU with flags
// Pipeline: an accepted input word is held in the input register, and its
// result word is then captured in the result register.
// Throughput: one word per cycle unless m_axis_tready stalls it; each
// register advances whenever the stage after it is empty or being drained.
// Reset: asynchronous, active low; clears both valid bits, data holds.
// ----------------------------------------------------------------------------
module z80_alu_with_flags (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operand_a[15:0], operand_b[31:16], flags_in[39:32], carry[40],
  // extra_byte[48:41], bit_index[51:49], indirect[52], wz_high[60:53],
  // interrupt_enable2[61], count_nonzero[62], zero[63]
  input  logic [zalu_pkg::InWidth-1:0]   s_axis_tdata,
  // kind[5:0]
  input  logic [zalu_pkg::UserWidth-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result[15:0], flags_out[23:16], memory_result[31:24], repeat_res[32]
  output logic [zalu_pkg::OutWidth-1:0]  m_axis_tdata
);

  // Input register.
  logic                           in_vld_q;
  logic [zalu_pkg::InWidth-1:0]   in_q;
  logic [zalu_pkg::UserWidth-1:0] kind_q;
  logic                           out_vld_q;
  logic [zalu_pkg::OutWidth-1:0]  out_q, out_d;
  logic                           out_en, in_en;

  assign out_en        = ~out_vld_q | m_axis_tready;
  assign in_en         = ~in_vld_q | out_en;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_en) in_vld_q <= s_axis_tvalid;
      if (out_en) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid) begin
      in_q   <= s_axis_tdata;
      kind_q <= s_axis_tuser;
    end
    if (out_en && in_vld_q) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Field unpacking.
  logic [5:0]  kind;
  logic [15:0] wa, wb;
  logic [7:0]  a, b, f, extra, wzh;
  logic        ci, ind, iff2, cnz;
  logic [2:0]  bi;

  assign kind  = kind_q;
  assign wa    = in_q[15:0];
  assign wb    = in_q[31:16];
  assign f     = in_q[39:32];
  assign ci    = in_q[40];
  assign extra = in_q[48:41];
  assign bi    = in_q[51:49];
  assign ind   = in_q[52];
  assign wzh   = in_q[60:53];
  assign iff2  = in_q[61];
  assign cnz   = in_q[62];
  assign a     = wa[7:0];
  assign b     = wb[7:0];

  // Shared adders.
  logic [8:0]  sum8, dif8;
  logic [16:0] sum16, dif16;
  logic        c8;
  logic [7:0]  mask;

  assign c8    = (kind == zalu_pkg::OpAdc || kind == zalu_pkg::OpSbc) ? ci : 1'b0;
  assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, c8};
  assign dif8  = {1'b0, a} - {1'b0, b} - {8'd0, c8};
  assign sum16 = {1'b0, wa} + {1'b0, wb} +
                 {16'd0, (kind == zalu_pkg::OpAdc16) ? ci : 1'b0};
  assign dif16 = {1'b0, wa} - {1'b0, wb} - {16'd0, ci};
  assign mask  = 8'd1 << bi;

  // Operation decode.
  always_comb begin
    logic [15:0] res;
    logic [7:0]  fo, mem, r, adj, keep;
    logic        rep, lo, hi;
    logic [8:0]  t;
    res  = '0;
    fo   = '0;
    mem  = '0;
    rep  = 1'b0;
    r    = '0;
    adj  = '0;
    t    = '0;
    lo   = 1'b0;
    hi   = 1'b0;
    keep = f & 8'hC4;
    case (kind)
      zalu_pkg::OpAdd, zalu_pkg::OpAdc: begin
        res = {8'd0, sum8[7:0]};
        fo  = {sum8[7], sum8[7:0] == 8'd0, sum8[5], (a[4] ^ b[4] ^ sum8[4]), sum8[3],
               (a[7] == b[7]) && (b[7] != sum8[7]), 1'b0, sum8[8]};
      end
      zalu_pkg::OpSub, zalu_pkg::OpSbc, zalu_pkg::OpCp: begin
        if (kind != zalu_pkg::OpCp) res = {8'd0, dif8[7:0]};
        r  = (kind == zalu_pkg::OpCp) ? b : dif8[7:0];
        fo = {dif8[7], dif8[7:0] == 8'd0, r[5], (a[4] ^ b[4] ^ dif8[4]), r[3],
              (a[7] != b[7]) && (dif8[7] != a[7]), 1'b1, dif8[8]};
      end
      zalu_pkg::OpAnd: begin
        res = {8'd0, a & b};
        fo  = zalu_pkg::szp(a & b) | 8'h10;
      end
      zalu_pkg::OpXor: begin
        res = {8'd0, a ^ b};
        fo  = zalu_pkg::szp(a ^ b);
      end
      zalu_pkg::OpOr: begin
        res = {8'd0, a | b};
        fo  = zalu_pkg::szp(a | b);
      end
      zalu_pkg::OpIn: fo = zalu_pkg::szp(b) | {7'd0, f[0]};
      zalu_pkg::OpInc: begin
        r   = b + 8'd1;
        res = {8'd0, r};
        fo  = {r[7], r == 8'd0, r[5], r[4] ^ b[4], r[3], r == 8'h80, 1'b0, ci};
      end
      zalu_pkg::OpDec: begin
        r   = b - 8'd1;
        res = {8'd0, r};
        fo  = {r[7], r == 8'd0, r[5], r[4] ^ b[4], r[3], r == 8'h7F, 1'b1, ci};
      end
      zalu_pkg::OpRlca, zalu_pkg::OpRrca, zalu_pkg::OpRla, zalu_pkg::OpRra: begin
        case (kind)
          zalu_pkg::OpRlca: r = {a[6:0], a[7]};
          zalu_pkg::OpRrca: r = {a[0], a[7:1]};
          zalu_pkg::OpRla:  r = {a[6:0], f[0]};
          default:          r = {f[0], a[7:1]};
        endcase
        res = {8'd0, r};
        fo  = keep | (r & 8'h28) |
              {7'd0, (kind == zalu_pkg::OpRlca || kind == zalu_pkg::OpRla) ? a[7] : a[0]};
      end
      zalu_pkg::OpDaa: begin
        lo  = (a[3:0] > 4'd9) || f[4];
        hi  = (a > 8'h99) || f[0];
        adj = (lo ? 8'h06 : 8'h00) + (hi ? 8'h60 : 8'h00);
        r   = f[1] ? (a - adj) : (a + adj);
        res = {8'd0, r};
        fo  = (f & 8'h03) | {7'd0, a > 8'h99} | ((a ^ r) & 8'h10) | zalu_pkg::szp(r);
      end
      zalu_pkg::OpCpl: begin
        r   = ~a;
        res = {8'd0, r};
        fo  = (f & 8'hC5) | 8'h12 | (r & 8'h28);
      end
      zalu_pkg::OpScf: fo = (f & 8'hC5) | 8'h01 | (a & 8'h28);
      zalu_pkg::OpCcf:
        fo = ((f & 8'hC5) | {3'd0, f[0], 4'd0} | (a & 8'h28)) ^ 8'h01;
      zalu_pkg::OpAdd16: begin
        res = sum16[15:0];
        fo  = keep | {2'b00, sum16[13], wa[12] ^ wb[12] ^ sum16[12], sum16[11],
                      2'b00, sum16[16]};
      end
      zalu_pkg::OpAdc16: begin
        res = sum16[15:0];
        fo  = {sum16[15], sum16[15:0] == 16'd0, sum16[13],
               wa[12] ^ wb[12] ^ sum16[12], sum16[11],
               (wa[15] == wb[15]) && (wb[15] != sum16[15]), 1'b0, sum16[16]};
      end
      zalu_pkg::OpSbc16: begin
        res = dif16[15:0];
        fo  = {dif16[15], dif16[15:0] == 16'd0, dif16[13],
               wa[12] ^ wb[12] ^ dif16[12], dif16[11],
               (wa[15] != wb[15]) && (wa[15] != dif16[15]), 1'b1, dif16[16]};
      end
      zalu_pkg::OpLdAir:
        fo = {b[7], b == 8'd0, b[5], 1'b0, b[3], iff2, 1'b0, f[0]};
      zalu_pkg::OpLdi: begin
        r  = sum8[7:0];
        fo = (f & 8'hC1) | {2'b00, r[1], 1'b0, r[3], cnz, 2'b00};
      end
      zalu_pkg::OpCpi: begin
        r  = dif8[7:0];
        fo = {r[7], r == 8'd0, 4'd0, 1'b1, f[0]};
        if (r[3:0] > a[3:0]) begin
          fo[4] = 1'b1;
          r     = r - 8'd1;
        end
        fo[5] = r[1];
        fo[3] = r[3];
        fo[2] = cnz;
        rep   = cnz && !fo[6];
      end
      zalu_pkg::OpIni, zalu_pkg::OpOuti: begin
        t  = {1'b0, extra} + {1'b0, b};
        r  = {5'd0, t[2:0]} ^ a;
        fo = {a[7], a == 8'd0, a[5], t[8], a[3], ~^r, b[7], t[8]};
      end
      zalu_pkg::OpRrd: begin
        r   = {a[7:4], b[3:0]};
        res = {8'd0, r};
        mem = {a[3:0], b[7:4]};
        fo  = zalu_pkg::szp(r) | {7'd0, f[0]};
      end
      zalu_pkg::OpRld: begin
        r   = {a[7:4], b[7:4]};
        res = {8'd0, r};
        mem = {b[3:0], a[3:0]};
        fo  = zalu_pkg::szp(r) | {7'd0, f[0]};
      end
      zalu_pkg::OpRlc, zalu_pkg::OpRl, zalu_pkg::OpSla, zalu_pkg::OpSll: begin
        case (kind)
          zalu_pkg::OpRlc: r = {a[6:0], a[7]};
          zalu_pkg::OpRl:  r = {a[6:0], ci};
          zalu_pkg::OpSla: r = {a[6:0], 1'b0};
          default:         r = {a[6:0], 1'b1};
        endcase
        res = {8'd0, r};
        fo  = zalu_pkg::szp(r) | {7'd0, a[7]};
      end
      zalu_pkg::OpRrc, zalu_pkg::OpRr, zalu_pkg::OpSra, zalu_pkg::OpSrl: begin
        case (kind)
          zalu_pkg::OpRrc: r = {a[0], a[7:1]};
          zalu_pkg::OpRr:  r = {ci, a[7:1]};
          zalu_pkg::OpSra: r = {a[7], a[7:1]};
          default:         r = {1'b0, a[7:1]};
        endcase
        res = {8'd0, r};
        fo  = zalu_pkg::szp(r) | {7'd0, a[0]};
      end
      zalu_pkg::OpBit: begin
        r  = b & mask;
        fo = {r[7], r == 8'd0, 1'b0, 1'b1, 1'b0, r == 8'd0, 1'b0, ci};
        fo = fo | ((ind ? wzh : b) & 8'h28);
      end
      zalu_pkg::OpRes: res = {8'd0, b & ~mask};
      zalu_pkg::OpSet: res = {8'd0, b | mask};
      default: ;
    endcase
    out_d = {7'd0, rep, mem, fo, res};
  end

`ifndef ASSERT_OFF
  // A result word never appears without a word having entered the stage before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_vld_q))
    else $error("result valid without staged word");
  // Memory byte is zero unless a digit rotate produced it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && kind != zalu_pkg::OpRrd && kind != zalu_pkg::OpRld) |-> out_d[31:24] == 8'd0)
    else $error("memory byte set by wrong operation");
  // Repeat is only raised by block compare.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && kind != zalu_pkg::OpCpi) |-> !out_d[32])
    else $error("repeat raised by wrong operation");
`endif

endmodule

// ----- sim/z80_alu_with_flags_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z80 ALU flag checker
// Watches the input and result channels of the ALU. Every accepted input
// word is decoded from the bits that actually reach the port, its result and
// flags are computed here, and each result word is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_checker
  import zalu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [InWidth-1:0]    s_axis_tdata,
  input  logic [UserWidth-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OutWidth-1:0]   m_axis_tdata,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam logic [31:0] MS  = 32'h1 << FlS;
  localparam logic [31:0] MZ  = 32'h1 << FlZ;
  localparam logic [31:0] MY  = 32'h1 << FlY;
  localparam logic [31:0] MH  = 32'h1 << FlH;
  localparam logic [31:0] MX  = 32'h1 << FlX;
  localparam logic [31:0] MPV = 32'h1 << FlPv;
  localparam logic [31:0] MN  = 32'h1 << FlN;
  localparam logic [31:0] MC  = 32'h1 << FlC;
  localparam logic [31:0] MXY = MX | MY;

  // Laid out from the top bit down, so the result sits in the low bits.
  typedef struct packed {
    logic        rep;
    logic [7:0]  mem;
    logic [7:0]  flags;
    logic [15:0] result;
  } alu_out_t;

  alu_out_t expected_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [31:0] sign_zero(input logic [31:0] v);
    v &= 32'hFF;
    return (v != 0) ? (v & MS) : MZ;
  endfunction

  function automatic logic [31:0] even_pv(input logic [31:0] v);
    return (^v[7:0]) ? 32'h0 : MPV;
  endfunction

  function automatic logic [31:0] byte_szp(input logic [31:0] v);
    return sign_zero(v) | (v & MXY) | even_pv(v);
  endfunction

  function automatic logic [31:0] sum_fl(input logic [31:0] a, b, r);
    return sign_zero(r) | (r & MXY) | ((r >> 8) & MC) | ((a ^ b ^ r) & MH)
         | ((((b ^ a ^ 32'h80) & (b ^ r)) >> 5) & MPV);
  endfunction

  function automatic logic [31:0] diff_fl(input logic [31:0] a, b, r, xy);
    return MN | sign_zero(r) | (xy & MXY) | ((r >> 8) & MC)
         | ((a ^ b ^ r) & MH) | ((((b ^ a) & (r ^ a)) >> 5) & MPV);
  endfunction

  // Computes the ALU outcome of one input word.
  function automatic alu_out_t alu_predict(input logic [UserWidth-1:0] kind,
                                           input logic [InWidth-1:0] w);
    logic [31:0] wa, wb, a, b, f, ci, extra, bi, ind, wzh, iff2, cnz;
    logic [31:0] res, fo, mem, rep, r, t, keep, adj;
    logic        lo, hi;
    alu_out_t    o;
    wa    = 32'(w[15:0]);
    wb    = 32'(w[31:16]);
    a     = wa & 32'hFF;
    b     = wb & 32'hFF;
    f     = 32'(w[39:32]);
    ci    = 32'(w[40]);
    extra = 32'(w[48:41]);
    bi    = 32'(w[51:49]);
    ind   = 32'(w[52]);
    wzh   = 32'(w[60:53]);
    iff2  = 32'(w[61]);
    cnz   = 32'(w[62]);
    res = 0; fo = 0; mem = 0; rep = 0;
    keep = f & (MS | MZ | MPV);
    case (kind)
      OpAdd: begin r = a + b; res = r & 32'hFF; fo = sum_fl(a, b, r); end
      OpAdc: begin r = a + b + ci; res = r & 32'hFF; fo = sum_fl(a, b, r); end
      OpSub: begin
        r = (a - b) & 32'hFFFF; res = r & 32'hFF; fo = diff_fl(a, b, r, r);
      end
      OpSbc: begin
        r = (a - b - ci) & 32'hFFFF; res = r & 32'hFF; fo = diff_fl(a, b, r, r);
      end
      OpAnd: begin res = a & b; fo = byte_szp(res) | MH; end
      OpXor: begin res = a ^ b; fo = byte_szp(res); end
      OpOr:  begin res = a | b; fo = byte_szp(res); end
      // Compare takes its undocumented bits from the operand.
      OpCp:  begin r = (a - b) & 32'hFFFF; fo = diff_fl(a, b, r, b); end
      OpIn:  fo = byte_szp(b) | (f & MC);
      OpInc: begin
        res = (b + 1) & 32'hFF;
        fo = sign_zero(res) | (res & MXY) | ((res ^ b) & MH) | ci;
        if (res == 32'h80) fo |= MPV;
      end
      OpDec: begin
        res = (b - 1) & 32'hFF;
        fo = MN | sign_zero(res) | (res & MXY) | ((res ^ b) & MH) | ci;
        if (res == 32'h7F) fo |= MPV;
      end
      OpRlca: begin
        res = ((a << 1) | (a >> 7)) & 32'hFF; fo = (a >> 7) | keep | (res & MXY);
      end
      OpRrca: begin
        res = ((a >> 1) | (a << 7)) & 32'hFF; fo = (a & MC) | keep | (res & MXY);
      end
      OpRla: begin
        res = ((a << 1) | (f & MC)) & 32'hFF; fo = (a >> 7) | keep | (res & MXY);
      end
      OpRra: begin
        res = (a >> 1) | ((f & MC) << 7); fo = (a & MC) | keep | (res & MXY);
      end
      OpDaa: begin
        lo  = ((a & 32'hF) > 9) || ((f & MH) != 0);
        hi  = (a > 32'h99) || ((f & MC) != 0);
        adj = (lo ? 32'h06 : 32'h0) + (hi ? 32'h60 : 32'h0);
        res = (((f & MN) != 0) ? (a - adj) : (a + adj)) & 32'hFF;
        fo  = (f & (MC | MN)) | ((a > 32'h99) ? MC : 32'h0) | ((a ^ res) & MH)
            | byte_szp(res);
      end
      OpCpl: begin res = a ^ 32'hFF; fo = (f & 32'hC5) | MH | MN | (res & MXY); end
      OpScf: fo = (f & 32'hC5) | MC | (a & MXY);
      OpCcf: fo = ((f & 32'hC5) | ((f & MC) << 4) | (a & MXY)) ^ MC;
      OpAdd16: begin
        r = wa + wb; res = r & 32'hFFFF;
        fo = keep | (((wa ^ r ^ wb) >> 8) & MH) | ((r >> 16) & MC) | ((r >> 8) & MXY);
      end
      OpAdc16, OpSbc16: begin
        if (kind == OpAdc16) begin
          r  = wa + wb + ci;
          fo = ((wb ^ wa ^ 32'h8000) & (wb ^ r) & 32'h8000) >> 13;
        end else begin
          r  = (wa - wb - ci) & 32'h1FFFF;
          fo = MN | (((wb ^ wa) & (wa ^ r) & 32'h8000) >> 13);
        end
        res = r & 32'hFFFF;
        fo |= (((wa ^ r ^ wb) >> 8) & MH) | ((r >> 16) & MC) | ((r >> 8) & (MS | MXY))
            | ((res == 0) ? MZ : 32'h0);
      end
      OpLdAir: fo = (f & MC) | sign_zero(b) | (b & MXY) | ((iff2 != 0) ? MPV : 32'h0);
      OpLdi: begin
        r  = (a + b) & 32'hFF;
        fo = (f & (MS | MZ | MC)) | (((r & 2) != 0) ? MY : 32'h0) | (r & MX)
           | ((cnz != 0) ? MPV : 32'h0);
      end
      // Block compare: half borrow lowers the value that feeds X and Y.
      OpCpi: begin
        r  = (a - b) & 32'hFF;
        fo = (f & MC) | MN | sign_zero(r);
        if ((r & 32'hF) > (a & 32'hF)) begin
          fo |= MH;
          r = (r - 1) & 32'hFF;
        end
        if ((r & 2) != 0) fo |= MY;
        fo |= r & MX;
        if (cnz != 0) fo |= MPV;
        rep = ((cnz != 0) && ((fo & MZ) == 0)) ? 32'h1 : 32'h0;
      end
      OpIni, OpOuti: begin
        fo = sign_zero(a) | (a & MXY);
        if ((b & 32'h80) != 0) fo |= MN;
        t = extra + b;
        if ((t & 32'h100) != 0) fo |= MH | MC;
        fo |= even_pv((t & 7) ^ a);
      end
      OpRrd: begin
        res = (a & 32'hF0) | (b & 32'h0F);
        mem = ((b >> 4) | (a << 4)) & 32'hFF;
        fo  = (f & MC) | byte_szp(res);
      end
      OpRld: begin
        res = (a & 32'hF0) | (b >> 4);
        mem = ((b << 4) | (a & 32'h0F)) & 32'hFF;
        fo  = (f & MC) | byte_szp(res);
      end
      OpRlc: begin res = ((a << 1) | (a >> 7)) & 32'hFF; fo = byte_szp(res) | (a >> 7); end
      OpRrc: begin res = ((a >> 1) | (a << 7)) & 32'hFF; fo = byte_szp(res) | (a & MC); end
      OpRl:  begin res = ((a << 1) | ci) & 32'hFF; fo = byte_szp(res) | (a >> 7); end
      OpRr:  begin res = (a >> 1) | (ci << 7); fo = byte_szp(res) | (a & MC); end
      OpSla: begin res = (a << 1) & 32'hFF; fo = byte_szp(res) | (a >> 7); end
      OpSra: begin res = (a >> 1) | (a & 32'h80); fo = byte_szp(res) | (a & MC); end
      OpSll: begin res = ((a << 1) | 1) & 32'hFF; fo = byte_szp(res) | (a >> 7); end
      OpSrl: begin res = a >> 1; fo = byte_szp(res) | (a & MC); end
      // Bit test on memory takes X and Y from the hidden address latch.
      OpBit: begin
        r  = b & (32'h1 << bi);
        fo = ci | MH | ((r != 0) ? (r & MS) : (MZ | MPV));
        fo |= ((ind != 0) ? wzh : b) & MXY;
      end
      OpRes: res = b & ~(32'h1 << bi) & 32'hFF;
      OpSet: res = (b | (32'h1 << bi)) & 32'hFF;
      default: ;
    endcase
    o.result = res[15:0];
    o.flags  = fo[7:0];
    o.mem    = mem[7:0];
    o.rep    = rep[0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  // Record predictions on accepted input words, check accepted result words.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_out_t got, want;
    if (!rst_ni) begin
      expected_q.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alu_out_t'(m_axis_tdata[32:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", 32'(got), 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (got.result != want.result)
            report_mismatch("result", 32'(got.result), 32'(want.result));
          if (got.flags != want.flags)
            report_mismatch("flags", 32'(got.flags), 32'(want.flags));
          if (got.mem != want.mem)
            report_mismatch("memory byte", 32'(got.mem), 32'(want.mem));
          if (got.rep != want.rep)
            report_mismatch("repeat", 32'(got.rep), 32'(want.rep));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(alu_predict(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

// ----- sim/z80_alu_with_flags_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z80 ALU regression
// Drives directed words for every operation and then random words through
// three flow-control phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_test;
  import zalu_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InWidth-1:0]   s_axis_tdata = '0;
  logic [UserWidth-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutWidth-1:0]  m_axis_tdata;
  int unsigned          fail_count, pending;
  int unsigned          send_idle = 0, recv_idle = 0;

  always #6 clk_i = ~clk_i;

  z80_alu_with_flags uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  z80_alu_with_flags_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side stalls at the rate of the current phase.
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  // Data fields from bit 0 up: operand_a, operand_b, flags_in, carry,
  // extra_byte, bit_index, indirect, wz_high, interrupt_enable2, count_nonzero.
  function automatic logic [InWidth-1:0] pack_word(
    input logic [15:0] a, b, input logic [7:0] f,
    input logic ci, input logic [7:0] extra, input logic [2:0] bi, input logic ind,
    input logic [7:0] wzh, input logic iff2, cnz);
    return {1'b0, cnz, iff2, wzh, ind, bi, extra, ci, f, b, a};
  endfunction

  task automatic send_word(input logic [UserWidth-1:0] kind, input logic [InWidth-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random;
    logic [5:0] kind;
    kind = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 40)) : 6'($urandom_range(39));
    send_word(kind, pack_word(16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                              8'($urandom), 3'($urandom), 1'($urandom), 8'($urandom),
                              1'($urandom), 1'($urandom)));
  endtask

  initial begin
    #3_000_000;
    $display("z80_alu_with_flags regression: fail");
    $finish;
  end

  initial begin
    op_e op;
    logic hi;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation with all fields at one extreme, alternating
    // all zeros and all ones, plus an undefined operation code.
    send_idle = 20; recv_idle = 72;
    for (int k = 0; k <= int'(OpSet); k++) begin
      op = op_e'(k);
      hi = k[0];
      send_word(op, pack_word(hi ? 16'hFFFF : 16'h0000, hi ? 16'hFFFF : 16'h0000,
                              hi ? 8'hFF : 8'h00, hi, hi ? 8'hFF : 8'h00, hi ? 3'd7 : 3'd0,
                              hi, hi ? 8'hFF : 8'h00, hi, hi));
    end
    send_word(6'h3F, pack_word(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 3'd7, 1'b1,
                               8'hFF, 1'b1, 1'b1));

    repeat (300) send_random();
    send_idle = 72; recv_idle = 20;
    repeat (300) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (300) send_random();
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("z80_alu_with_flags regression: pass");
    end else begin
      $display("z80_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule
